>>> src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the CRC16-CCITT-FALSE byte update for the
// frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int MAX_PAYLOAD  = 32;
    localparam int HDR_LEN      = 9;
    localparam int MIN_FRAME    = 11;
    localparam int WIN_DEPTH    = MAX_PAYLOAD + MIN_FRAME;
    localparam int WIN_SLOTS    = 64;
    localparam int PTR_W        = 6;
    localparam int OUT_W        = 176;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_VERSION      = 2'd2;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC,
        IDX_VER
    } idx_op_t;

    typedef enum logic [2:0] {
        DROP_NONE,
        DROP_ONE,
        DROP_POS,
        DROP_KEEP_LAST,
        DROP_FRAME
    } drop_op_t;

    typedef struct packed {
        logic     wr_byte;
        logic     rd;
        idx_op_t  idx_op;
        logic     idx_pay;
        logic     prev_ld;
        logic     hdr_ld;
        logic     crc_init;
        logic     crc_upd;
        logic     crc_lo_ld;
        drop_op_t drop;
        logic     inc_resync;
        logic     inc_lenrej;
        logic     inc_crcfail;
        logic     inc_good;
        logic     out_ld;
    } cfd_cmd_t;

    typedef struct packed {
        logic fill_lt_min;
        logic scan_hit;
        logic scan_end;
        logic pos_zero;
        logic hdr_done;
        logic ver_ok;
        logic len_bad;
        logic len_zero;
        logic frame_short;
        logic pay_done;
        logic crc_ok;
        logic out_free;
        logic emit_last;
    } cfd_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> src/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// Sequencer: accepts a byte, then scans, checks header, length and CRC of
// the window front and emits one result per payload byte, one if empty.
// ----------------------------------------------------------------------------
module cfd_ctrl
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cfd_status_t status,
    output cfd_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HDR_RD,
        S_HDR_LD,
        S_VER,
        S_PAY_RD,
        S_PAY_LD,
        S_CRC_RD_LO,
        S_CRC_LO,
        S_CRC_RD_HI,
        S_CRC_HI,
        S_EM_RD,
        S_EM_LD
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.drop   = DROP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.wr_byte = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.idx_op = IDX_CLR;
                state_next = status.fill_lt_min ? S_IDLE : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (status.scan_hit)
                begin
                    if (status.pos_zero)
                    begin
                        cmd.crc_init = 1'b1;
                        cmd.idx_op   = IDX_VER;
                        state_next   = S_HDR_RD;
                    end
                    else
                    begin
                        // drop up to the start pair, then rescan from the front
                        cmd.drop       = DROP_POS;
                        cmd.inc_resync = 1'b1;
                        state_next     = S_CHECK;
                    end
                end
                else if (status.scan_end)
                begin
                    cmd.drop       = DROP_KEEP_LAST;
                    cmd.inc_resync = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.prev_ld = 1'b1;
                    cmd.idx_op  = IDX_INC;
                    state_next  = S_SCAN_RD;
                end
            end
            S_HDR_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_HDR_LD;
            end
            S_HDR_LD:
            begin
                cmd.hdr_ld  = 1'b1;
                cmd.crc_upd = 1'b1;
                cmd.idx_op  = IDX_INC;
                state_next  = status.hdr_done ? S_VER : S_HDR_RD;
            end
            S_VER:
            begin
                if (!status.ver_ok)
                begin
                    cmd.drop       = DROP_ONE;
                    cmd.inc_resync = 1'b1;
                    state_next     = S_CHECK;
                end
                else if (status.len_bad)
                begin
                    cmd.drop       = DROP_ONE;
                    cmd.inc_lenrej = 1'b1;
                    state_next     = S_CHECK;
                end
                else if (status.frame_short)
                    state_next = S_IDLE;
                else if (status.len_zero)
                    state_next = S_CRC_RD_LO;
                else
                    state_next = S_PAY_RD;
            end
            S_PAY_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PAY_LD;
            end
            S_PAY_LD:
            begin
                cmd.crc_upd = 1'b1;
                cmd.idx_op  = IDX_INC;
                state_next  = status.pay_done ? S_CRC_RD_LO : S_PAY_RD;
            end
            S_CRC_RD_LO:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CRC_LO;
            end
            S_CRC_LO:
            begin
                cmd.crc_lo_ld = 1'b1;
                cmd.idx_op    = IDX_INC;
                state_next    = S_CRC_RD_HI;
            end
            S_CRC_RD_HI:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CRC_HI;
            end
            S_CRC_HI:
            begin
                if (status.crc_ok)
                begin
                    cmd.inc_good = 1'b1;
                    cmd.idx_pay  = 1'b1;
                    state_next   = S_EM_RD;
                end
                else
                begin
                    cmd.drop        = DROP_ONE;
                    cmd.inc_crcfail = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_EM_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    cmd.idx_op = IDX_INC;
                    if (status.emit_last)
                    begin
                        cmd.drop   = DROP_FRAME;
                        state_next = S_CHECK;
                    end
                    else
                        state_next = S_EM_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

>>> src/cfd_datapath.sv
// ----------------------------------------------------------------------------
// cfd_datapath
// Window ring memory, header registers, CRC, counters, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module cfd_datapath
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [7:0]         cfg_wdata,
    input  logic [7:0]         in_byte,
    input  cfd_cmd_t           cmd,
    output cfd_status_t        status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_last,
    output logic               out_user,
    output logic [OUT_W-1:0]   out_data
);

    logic [7:0] start_a_reg, start_b_reg, version_reg;

    logic [7:0] mem [WIN_SLOTS];
    logic [7:0] rdata_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [PTR_W-1:0] drop_n;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic             win_full;

    logic [7:0]  prev_reg;
    logic [7:0]  ver_reg, len_lo_reg, len_hi_reg, msg_reg, flags_reg, seq_lo_reg, seq_hi_reg;
    logic [15:0] crc_reg;
    logic [7:0]  crc_lo_reg;
    logic [5:0]  len6;
    logic [6:0]  flen;

    logic [31:0] good_reg, crcfail_reg, lenrej_reg, resync_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    logic             out_user_reg;
    logic [OUT_W-1:0] out_data_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_a_reg <= 8'hAA;
            start_b_reg <= 8'h55;
            version_reg <= 8'h01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_FIRST:  start_a_reg <= cfg_wdata;
                REG_START_SECOND: start_b_reg <= cfg_wdata;
                REG_VERSION:      version_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign len6     = len_lo_reg[5:0];
    assign flen     = 7'(MIN_FRAME) + {1'b0, len6};
    assign win_full = (fill_reg == PTR_W'(WIN_DEPTH));
    assign wr_addr  = win_full ? head_reg : head_reg + fill_reg;
    assign rd_addr  = head_reg + idx_reg;

    // window memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
            mem[wr_addr] <= in_byte;
        if (cmd.rd)
            rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (cmd.drop)
            DROP_ONE:       drop_n = PTR_W'(1);
            DROP_POS:       drop_n = idx_reg - PTR_W'(1);
            DROP_KEEP_LAST: drop_n = fill_reg - PTR_W'(1);
            DROP_FRAME:     drop_n = flen[PTR_W-1:0];
            default:        drop_n = '0;
        endcase
    end

    always_comb
    begin
        head_next = head_reg + drop_n;
        fill_next = fill_reg - drop_n;
        if (cmd.wr_byte)
            fill_next = win_full ? PTR_W'(1) : fill_reg + PTR_W'(1);
    end

    always_comb
    begin
        idx_next = idx_reg;
        case (cmd.idx_op)
            IDX_CLR: idx_next = '0;
            IDX_INC: idx_next = idx_reg + PTR_W'(1);
            IDX_VER: idx_next = PTR_W'(2);
            default: idx_next = idx_reg;
        endcase
        if (cmd.idx_pay)
            idx_next = PTR_W'(HDR_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            good_reg    <= '0;
            crcfail_reg <= '0;
            lenrej_reg  <= '0;
            resync_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            if (cmd.inc_good)
                good_reg <= good_reg + 32'd1;
            if (cmd.inc_crcfail)
                crcfail_reg <= crcfail_reg + 32'd1;
            if (cmd.inc_lenrej)
                lenrej_reg <= lenrej_reg + 32'd1;
            // a write into a full window empties it first
            if (cmd.inc_resync || (cmd.wr_byte && win_full))
                resync_reg <= resync_reg + 32'd1;
        end
    end

    // header, CRC
    always_ff @(posedge clk)
    begin
        if (cmd.prev_ld)
            prev_reg <= rdata_reg;
        if (cmd.hdr_ld)
        begin
            case (idx_reg)
                PTR_W'(2): ver_reg    <= rdata_reg;
                PTR_W'(3): len_lo_reg <= rdata_reg;
                PTR_W'(4): len_hi_reg <= rdata_reg;
                PTR_W'(5): msg_reg    <= rdata_reg;
                PTR_W'(6): flags_reg  <= rdata_reg;
                PTR_W'(7): seq_lo_reg <= rdata_reg;
                default:   seq_hi_reg <= rdata_reg;
            endcase
        end
        if (cmd.crc_init)
            crc_reg <= CRC_INIT;
        else if (cmd.crc_upd)
            crc_reg <= crc16_byte(crc_reg, rdata_reg);
        if (cmd.crc_lo_ld)
            crc_lo_reg <= rdata_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_ld)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_last_reg <= status.emit_last;
            out_user_reg <= !status.len_zero;
            out_data_reg <= {2'b00, resync_reg, lenrej_reg, crcfail_reg, good_reg,
                             status.len_zero ? 8'h00 : rdata_reg,
                             len6, seq_hi_reg, seq_lo_reg, flags_reg, msg_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;
    assign out_data  = out_data_reg;

    // status
    always_comb
    begin
        status.fill_lt_min = (fill_reg < PTR_W'(MIN_FRAME));
        status.scan_hit    = (idx_reg != '0) && (prev_reg == start_a_reg)
                             && (rdata_reg == start_b_reg);
        status.scan_end    = (idx_reg == fill_reg - PTR_W'(1));
        status.pos_zero    = (idx_reg == PTR_W'(1));
        status.hdr_done    = (idx_reg == PTR_W'(HDR_LEN - 1));
        status.ver_ok      = (ver_reg == version_reg);
        status.len_bad     = ({len_hi_reg, len_lo_reg} > 16'(MAX_PAYLOAD));
        status.len_zero    = (len6 == '0);
        status.frame_short = ({1'b0, fill_reg} < flen);
        status.pay_done    = (idx_reg == PTR_W'(HDR_LEN - 1) + len6);
        status.crc_ok      = ({rdata_reg, crc_lo_reg} == crc_reg);
        status.out_free    = !out_valid_reg || out_ready;
        status.emit_last   = status.len_zero || status.pay_done;
    end

endmodule

>>> src/crc_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// crc_frame_deframer_core
// Start-pattern / length / CRC16-CCITT-FALSE deframer for a received
// byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries one received byte per transaction. m_axis_* carries one
//   result per payload byte of each good frame (one result for an empty
//   frame), tuser flagging a valid payload byte and tlast marking the final
//   result of the frame.
//   cfg_we/cfg_addr/cfg_wdata write the two start bytes (index 0, 1) and the
//   expected version (index 2); write only while the block is idle.
//   The block takes one byte at a time. After a byte is taken it works on
//   the window through a single-port ring memory, with a read state ahead
//   of each byte used: a start scan, a header pass, the payload CRC and the
//   received CRC, then a read and a load for each emitted result. Each
//   single-byte drop restarts the scan, so the busy time per byte is
//   longest when a full window of bad candidates is dropped one byte at
//   a time.
//   Reset empties the window, clears all counters and loads the default
//   start bytes 0xAA 0x55 and version 0x01.
//   A stalled receiver holds the output register; the sequencer waits and
//   takes no new byte until the frame's last result is in that register.
// ----------------------------------------------------------------------------
module crc_frame_deframer_core
    import cfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [7:0]       cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // msg_id, frame_flags, seq_number, data_len, payload_byte,
    // good_frames, crc_failures, length_rejects, resync_events, zero pad
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser,   // has_byte
    output logic             m_axis_tlast    // last
);

    cfd_cmd_t    cmd;
    cfd_status_t status;

    cfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cfd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

endmodule
